[design/alwe_pkg.sv]
// Package for the alert limit word encoder.
// Holds field widths, scaling constants, pipeline enable struct and the CRC-8 functions.
// No dependencies.
package alwe_pkg;

  localparam int HUM_W  = 16;
  localparam int TEMP_W = 17;
  localparam int BYTE_W = 8;
  localparam int RAW_W  = 16;

  // Spans in whole units (percent, degrees C)
  localparam int HUM_SPAN    = 100;
  localparam int TEMP_OFFSET = 45;
  localparam int TEMP_SPAN   = 175;
  localparam int TEMP_MAX    = 130;

  // Scaled numerators: at most span * 65535
  localparam int MH_W = 23;
  localparam int MT_W = 24;
  // Offset temperature, non-negative when in range
  localparam int TU_W = 19;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

  // Load enables for the two stages of the constant divider
  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] crc8_word(input logic [BYTE_W-1:0] hi,
                                                  input logic [BYTE_W-1:0] lo);
    return crc8_byte(crc8_byte(CRC_INIT, hi), lo);
  endfunction

endpackage

[design/alwe_if.sv]
// Handshake interfaces for the alert limit word encoder channels.
// Depends on alwe_pkg for field widths.
interface alwe_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [alwe_pkg::HUM_W-1:0]    humidity_limit;
  logic signed [alwe_pkg::TEMP_W-1:0]   temperature_limit;

  modport source (output valid, output humidity_limit, output temperature_limit,
                  input ready);
  modport sink (input valid, input humidity_limit, input temperature_limit,
                output ready);
endinterface

interface alwe_out_if;
  logic                          valid;
  logic                          ready;
  logic [alwe_pkg::BYTE_W-1:0]   word_high;
  logic [alwe_pkg::BYTE_W-1:0]   word_low;
  logic [alwe_pkg::BYTE_W-1:0]   checksum;
  logic                          out_of_range;

  modport source (output valid, output word_high, output word_low, output checksum,
                  output out_of_range, input ready);
  modport sink (input valid, input word_high, input word_low, input checksum,
                input out_of_range, output ready);
endinterface

[design/alwe_cdiv.sv]
// Two-stage floor division by a constant: reciprocal multiply, then one correction step.
// Depends on alwe_pkg for the stage enable struct.
module alwe_cdiv #(
  parameter int WIDTH   = 24,
  parameter int DIVISOR = 175,
  parameter int QW      = 16
) (
  input  logic                        clk_i,
  input  alwe_pkg::stage_en_t         en_i,
  input  logic [WIDTH-1:0]            x_i,
  output logic [QW-1:0]               q_o
);

  // floor(2^32 / DIVISOR); estimate is low by at most one for x < 2^32
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIVISOR);

  logic [WIDTH+32:0] prod;
  logic [QW-1:0]     qest_d, qest_q;
  logic [WIDTH-1:0]  x_q;
  logic [WIDTH-1:0]  back;
  logic [WIDTH-1:0]  rem;
  logic [QW-1:0]     q_d, q_q;

  assign prod   = (WIDTH+33)'(x_i) * (WIDTH+33)'(RECIP);
  assign qest_d = prod[32 +: QW];

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      qest_q <= qest_d;
      x_q    <= x_i;
    end
  end

  assign back = WIDTH'(qest_q * DIVISOR);
  assign rem  = x_q - back;
  assign q_d  = (rem >= WIDTH'(DIVISOR)) ? qest_q + QW'(1) : qest_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

[design/alert_limit_word_encoder_crc8.sv]
// Top level of the alert limit word encoder: range check, scaling, packing, CRC-8.
// Depends on alwe_pkg, alwe_if.sv (alwe_in_if, alwe_out_if) and alwe_cdiv.
//
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+------------------
//  in_i     | in  | humidity_limit, temperature_limit                | valid && ready
//  out_o    | out | word_high, word_low, checksum, out_of_range      | valid && ready
//
// Five register stages: input, scaled numerators, divider estimate, divider
// result, output. Throughput is one item per cycle while the output is not stalled.
// Each stage loads when it is empty or the stage after it moves on, so
// bubbles close up and a stalled output holds while earlier stages keep filling.
// Reset clears the stage valid bits only.
module alert_limit_word_encoder_crc8 #(
  parameter int FRACTION_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  alwe_in_if.sink    in_i,
  alwe_out_if.source out_o
);

  localparam int HUM_MAX  = alwe_pkg::HUM_SPAN << FRACTION_BITS;
  localparam int TEMP_LO  = -(alwe_pkg::TEMP_OFFSET << FRACTION_BITS);
  localparam int TEMP_HI  = alwe_pkg::TEMP_MAX << FRACTION_BITS;
  localparam int TEMP_OFF = alwe_pkg::TEMP_OFFSET << FRACTION_BITS;
  localparam int PH_W     = 15 + 17;
  localparam int PT_W     = alwe_pkg::TU_W + 17;

  // Pipeline control
  logic [4:0] v_q;
  logic [4:0] rdy;
  logic [4:0] ld;

  assign rdy[4] = !v_q[4] || out_o.ready;
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];

  assign ld[0] = rdy[0] && in_i.valid;
  assign ld[1] = rdy[1] && v_q[0];
  assign ld[2] = rdy[2] && v_q[1];
  assign ld[3] = rdy[3] && v_q[2];
  assign ld[4] = rdy[4] && v_q[3];

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  // Stage 0: input register
  logic signed [alwe_pkg::HUM_W-1:0]  h_q;
  logic signed [alwe_pkg::TEMP_W-1:0] t_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      h_q <= in_i.humidity_limit;
      t_q <= in_i.temperature_limit;
    end
  end

  // Range check and numerators scaled by 65535, fraction bits dropped
  logic signed [31:0]           h_ext, t_ext, t_sum;
  logic                         oor_d;
  logic [14:0]                  hu;
  logic [alwe_pkg::TU_W-1:0]    tu;
  logic [PH_W-1:0]              ph;
  logic [PT_W-1:0]              pt;
  logic [alwe_pkg::MH_W-1:0]    mh_d, mh_q;
  logic [alwe_pkg::MT_W-1:0]    mt_d, mt_q;
  logic [3:1]                   oor_q;

  assign h_ext = 32'(h_q);
  assign t_ext = 32'(t_q);
  assign oor_d = (h_ext < 0) || (h_ext > HUM_MAX) || (t_ext < TEMP_LO) || (t_ext > TEMP_HI);
  assign t_sum = t_ext + 32'(TEMP_OFF);
  assign hu    = h_q[14:0];
  assign tu    = t_sum[alwe_pkg::TU_W-1:0];
  assign ph    = (PH_W'(hu) << 16) - PH_W'(hu);
  assign pt    = (PT_W'(tu) << 16) - PT_W'(tu);
  assign mh_d  = alwe_pkg::MH_W'(ph >> FRACTION_BITS);
  assign mt_d  = alwe_pkg::MT_W'(pt >> FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      mh_q     <= mh_d;
      mt_q     <= mt_d;
      oor_q[1] <= oor_d;
    end
    if (ld[2]) oor_q[2] <= oor_q[1];
    if (ld[3]) oor_q[3] <= oor_q[2];
  end

  // Stages 2 and 3: division by the spans
  alwe_pkg::stage_en_t             div_en;
  logic [alwe_pkg::RAW_W-1:0]      raw_h, raw_t;

  assign div_en.s2 = ld[2];
  assign div_en.s3 = ld[3];

  alwe_cdiv #(
    .WIDTH   (alwe_pkg::MH_W),
    .DIVISOR (alwe_pkg::HUM_SPAN),
    .QW      (alwe_pkg::RAW_W)
  ) u_div_h (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (mh_q),
    .q_o   (raw_h)
  );

  alwe_cdiv #(
    .WIDTH   (alwe_pkg::MT_W),
    .DIVISOR (alwe_pkg::TEMP_SPAN),
    .QW      (alwe_pkg::RAW_W)
  ) u_div_t (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (mt_q),
    .q_o   (raw_t)
  );

  // Stage 4: pack, CRC, output register
  logic [2*alwe_pkg::BYTE_W-1:0] word;
  logic [alwe_pkg::BYTE_W-1:0]   hi_d, lo_d, crc_d;
  logic [alwe_pkg::BYTE_W-1:0]   hi_q, lo_q, crc_q;
  logic                          oor4_q;

  assign word  = {raw_h[15:9], raw_t[15:7]};
  assign hi_d  = oor_q[3] ? '0 : word[15:8];
  assign lo_d  = oor_q[3] ? '0 : word[7:0];
  assign crc_d = oor_q[3] ? '0 : alwe_pkg::crc8_word(word[15:8], word[7:0]);

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      crc_q  <= crc_d;
      oor4_q <= oor_q[3];
    end
  end

  assign out_o.valid        = v_q[4];
  assign out_o.word_high    = hi_q;
  assign out_o.word_low     = lo_q;
  assign out_o.checksum     = crc_q;
  assign out_o.out_of_range = oor4_q;

  // Checks
  logic in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("pipeline occupancy did not grow on input transfer");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> ($countones(v_q) + 1 == $past($countones(v_q))))
    else $error("pipeline occupancy did not shrink on output transfer");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v_q && !out_o.ready))
    else $error("input stalled while pipeline has room");

  a_crc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.out_of_range) |->
      (out_o.checksum == alwe_pkg::crc8_word(out_o.word_high, out_o.word_low)))
    else $error("checksum does not match packed word");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_of_range) |->
      (out_o.word_high == '0 && out_o.word_low == '0 && out_o.checksum == '0))
    else $error("out of range result carries nonzero bytes");

endmodule

[tb/alwe_limit_word_monitor.sv]
// Scoreboard for the alert limit word encoder: watches both channels, predicts each
// limit word and CRC-8 from the accepted inputs and compares the results in order.
// Depends on alwe_pkg for field widths.
module alwe_limit_word_monitor #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [alwe_pkg::HUM_W-1:0]   humidity_i,
  input  logic signed [alwe_pkg::TEMP_W-1:0]  temperature_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [alwe_pkg::BYTE_W-1:0]         word_high_i,
  input  logic [alwe_pkg::BYTE_W-1:0]         word_low_i,
  input  logic [alwe_pkg::BYTE_W-1:0]         checksum_i,
  input  logic                                out_of_range_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  flagged_o
);

  localparam longint FULL_CODE   = 65535;
  localparam longint HUM_PCT     = 100;
  localparam longint TEMP_LOW_C  = 45;
  localparam longint TEMP_HIGH_C = 130;
  localparam longint TEMP_RANGE  = 175;
  localparam logic [7:0] CRC_SEED = 8'hFF;
  localparam logic [7:0] CRC_TAPS = 8'h31;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] word_high;
    logic [7:0] word_low;
    logic [7:0] checksum;
    logic       out_of_range;
  } limit_word_t;

  limit_word_t pending_words[$];

  function automatic limit_word_t encode_limits(input logic signed [alwe_pkg::HUM_W-1:0]  hum,
                                                input logic signed [alwe_pkg::TEMP_W-1:0] temp);
    longint      unit, h, t, raw_h, raw_t;
    logic [15:0] word;
    logic [7:0]  crc;
    logic        fb;
    int          i;
    limit_word_t r;
    unit = longint'(1) << FRACTION_BITS;
    h = hum;
    t = temp;
    r = '0;
    if (h < 0 || h > HUM_PCT * unit || t < -TEMP_LOW_C * unit || t > TEMP_HIGH_C * unit) begin
      r.out_of_range = 1'b1;
      return r;
    end
    raw_h = (h * FULL_CODE) / (HUM_PCT * unit);
    raw_t = ((t + TEMP_LOW_C * unit) * FULL_CODE) / (TEMP_RANGE * unit);
    word = {raw_h[15:9], raw_t[15:7]};
    // bit-serial CRC, MSB first over the whole 16-bit word
    crc = CRC_SEED;
    for (i = 15; i >= 0; i--) begin
      fb = crc[7] ^ word[i];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_TAPS;
      end
    end
    r.word_high = word[15:8];
    r.word_low = word[7:0];
    r.checksum = crc;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    limit_word_t want;
    limit_word_t got;
    if (!rst_ni) begin
      pending_words.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      flagged_o <= 0;
    end else begin
      // check the output first: nothing can leave in the cycle it enters
      if (out_valid_i && out_ready_i) begin
        got = {word_high_i, word_low_i, checksum_i, out_of_range_i};
        if (pending_words.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT) begin
            $display("unexpected result: hi %02h lo %02h crc %02h oor %b",
                     got.word_high, got.word_low, got.checksum, got.out_of_range);
          end
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_words.pop_front();
          if (got.word_high !== want.word_high || got.word_low !== want.word_low ||
              got.checksum !== want.checksum || got.out_of_range !== want.out_of_range) begin
            if (fail_count_o < REPORT_LIMIT) begin
              $write("result mismatch: exp hi %02h lo %02h crc %02h oor %b,",
                     want.word_high, want.word_low, want.checksum, want.out_of_range);
              $display(" got hi %02h lo %02h crc %02h oor %b",
                       got.word_high, got.word_low, got.checksum, got.out_of_range);
            end
            fail_count_o <= fail_count_o + 1;
          end
          checked_o <= checked_o + 1;
          if (want.out_of_range) begin
            flagged_o <= flagged_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_words.push_back(encode_limits(humidity_i, temperature_i));
      end
      pending_o <= pending_words.size();
    end
  end

endmodule

[tb/tb_alert_limit_word_encoder_crc8.sv]
// Top of the alert limit word encoder testbench: clock, reset, stimulus and verdict.
// Depends on alwe_pkg, alwe_if.sv, the encoder RTL and alwe_limit_word_monitor.
module tb_alert_limit_word_encoder_crc8;

  localparam int FRACTION_BITS = 8;
  localparam int ONE = 1 << FRACTION_BITS;
  localparam int HUM_MAX_FX = 100 * ONE;
  localparam int TEMP_MIN_FX = -45 * ONE;
  localparam int TEMP_MAX_FX = 130 * ONE;
  localparam int STALL_BURST = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  alwe_in_if  in_ch ();
  alwe_out_if out_ch ();

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  burst_req = 1'b0;
  int  quiet_cycles = 0;
  int  fail_count, pending, checked, flagged;

  alert_limit_word_encoder_crc8 #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  alwe_limit_word_monitor #(
    .FRACTION_BITS(FRACTION_BITS)
  ) limit_word_mon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .humidity_i    (in_ch.humidity_limit),
    .temperature_i (in_ch.temperature_limit),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .word_high_i   (out_ch.word_high),
    .word_low_i    (out_ch.word_low),
    .checksum_i    (out_ch.checksum),
    .out_of_range_i(out_ch.out_of_range),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .flagged_o     (flagged)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.humidity_limit = '0;
    in_ch.temperature_limit = '0;
    out_ch.ready = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (burst_req) begin
        burst_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (STALL_BURST - 1) begin
          @(negedge clk_i);
          out_ch.ready <= 1'b0;
        end
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_alert_limit_word_encoder_crc8 failed");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_limits(input int hum, input int temp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.humidity_limit <= hum[alwe_pkg::HUM_W-1:0];
    in_ch.temperature_limit <= temp[alwe_pkg::TEMP_W-1:0];
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random_limits();
    int sel, hum, temp;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      hum = int'($urandom_range(0, HUM_MAX_FX));
      temp = int'($urandom_range(0, TEMP_MAX_FX - TEMP_MIN_FX)) + TEMP_MIN_FX;
    end else if (sel < 82) begin
      // hug the span bounds from both sides
      hum = ($urandom_range(0, 1) ? HUM_MAX_FX : 0) + int'($urandom_range(0, 4)) - 2;
      temp = ($urandom_range(0, 1) ? TEMP_MAX_FX : TEMP_MIN_FX) + int'($urandom_range(0, 4)) - 2;
    end else begin
      hum = int'($urandom);
      temp = int'($urandom);
    end
    send_limits(hum, temp);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) send_random_limits();
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners: exact bounds, one step inside and outside, field extremes
    send_limits(0, TEMP_MIN_FX);
    send_limits(HUM_MAX_FX, TEMP_MAX_FX);
    send_limits(0, TEMP_MAX_FX);
    send_limits(HUM_MAX_FX, TEMP_MIN_FX);
    send_limits(1, TEMP_MIN_FX + 1);
    send_limits(HUM_MAX_FX - 1, TEMP_MAX_FX - 1);
    send_limits(HUM_MAX_FX / 2, 0);
    send_limits(-1, 0);
    send_limits(HUM_MAX_FX + 1, 0);
    send_limits(HUM_MAX_FX / 2, TEMP_MIN_FX - 1);
    send_limits(HUM_MAX_FX / 2, TEMP_MAX_FX + 1);
    send_limits(32767, 0);
    send_limits(-32768, 0);
    send_limits(0, 65535);
    send_limits(0, -65536);
    send_limits(-32768, -65536);
    send_limits(32767, 65535);
    send_limits(HUM_MAX_FX, TEMP_MAX_FX);

    burst_req = 1'b1;
    run_phase(0, 0, 300);
    run_phase(79, 0, 280);
    run_phase(0, 79, 280);
    run_phase(33, 33, 275);
    in_ch.valid <= 1'b0;

    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d limit words, %0d of them flagged out of range", checked, flagged);
    $display("phases: back-to-back, sparse input, stalled output, mixed, one long output hold");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_alert_limit_word_encoder_crc8 passed");
    end else begin
      $display("tb_alert_limit_word_encoder_crc8 failed");
    end
    $finish;
  end

endmodule
